// File: design/embd_pkg.sv
// shared types, constants and lane helpers for the emulated memory bus decoder
`default_nettype none

package embd_pkg;

   localparam logic [2:0] ACT_RD8   = 3'd0;
   localparam logic [2:0] ACT_RD16  = 3'd1;
   localparam logic [2:0] ACT_RD32  = 3'd2;
   localparam logic [2:0] ACT_WR8   = 3'd3;
   localparam logic [2:0] ACT_WR16  = 3'd4;
   localparam logic [2:0] ACT_WR32  = 3'd5;
   localparam logic [2:0] ACT_LOAD  = 3'd6;

   localparam logic [1:0] CSR_RAM_PRESENT = 2'd0;
   localparam logic [1:0] CSR_RAM_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_ROM_PRESENT = 2'd2;

   localparam int          CSR_DATA_W      = 21;
   localparam logic [20:0] RAM_LIMIT_RESET = 21'h100000;

   localparam logic [31:0] KSEG_MASK = 32'h1FFF_FFFF;
   localparam logic [15:0] SCR_PAGE  = 16'h7000;
   localparam logic [15:0] MBX_PAGE  = 16'h1000;
   localparam logic [15:0] GFX_PAGE  = 16'h1200;
   localparam logic [9:0]  ROM_PAGE  = 10'h07F;

   localparam int SCRATCH_WORDS = 4096;
   localparam int SCR_AW        = $clog2(SCRATCH_WORDS);

   typedef enum logic [2:0] {
      RGN_RAM  = 3'd0,
      RGN_ROM  = 3'd1,
      RGN_SCR  = 3'd2,
      RGN_MBX  = 3'd3,
      RGN_GFX  = 3'd4,
      RGN_NONE = 3'd5
   } region_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_LOAD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SZ_BYTE = 2'd0,
      SZ_HALF = 2'd1,
      SZ_WORD = 2'd2
   } size_type;

   typedef struct packed {
      logic        ram_present;
      logic [20:0] ram_limit;
      logic        rom_present;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      size_type    size;
      region_type  region;
      logic [31:0] phys;
   } dec_type;

   function automatic logic [31:0] lane_get(input logic [31:0] w, input logic [1:0] a,
                                            input size_type sz);
      logic [31:0] r;
      case (sz)
         SZ_WORD: r = w;
         SZ_HALF: r = {16'h0000, w[{a[1], 4'b0000} +: 16]};
         default: r = {24'h000000, w[{a, 3'b000} +: 8]};
      endcase
      return r;
   endfunction

   function automatic logic [31:0] lane_put(input logic [31:0] w, input logic [1:0] a,
                                            input size_type sz, input logic [31:0] d);
      logic [31:0] r;
      r = w;
      case (sz)
         SZ_WORD: r = d;
         SZ_HALF: r[{a[1], 4'b0000} +: 16] = d[15:0];
         default: r[{a, 3'b000} +: 8] = d[7:0];
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/embd_ram.sv
// generic single-port-write, registered-read synchronous ram
`default_nettype none

module embd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/embd_bank.sv
// one memory bank with forwarding of the most recent write over the read port
`default_nettype none

module embd_bank #(
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
   input  wire logic [31:0]              wr_data,
   output logic      [31:0]              rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0] rd_idx_ff;
   logic [AW-1:0] wr_idx_ff;
   logic [31:0]   wr_data_ff;
   logic          wr_vld_ff;
   logic          wr_vld_in;
   logic [31:0]   ram_rd_data;

   embd_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data)
   );

   assign wr_vld_in = wr_vld_ff | wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= wr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff <= rd_idx;
      end
      if (wr_en) begin
         wr_idx_ff  <= wr_idx;
         wr_data_ff <= wr_data;
      end
   end

   // a write in the read cycle is not seen by the ram, so take it from here
   assign rd_data = (wr_vld_ff && wr_idx_ff == rd_idx_ff) ? wr_data_ff : ram_rd_data;

endmodule

`default_nettype wire

// File: design/embd_decode.sv
// address translation and region priority decode of one bus access
`default_nettype none

module embd_decode
   import embd_pkg::*;
(
   input  wire logic [2:0]  action,
   input  wire logic [31:0] address,
   input  wire cfg_type     cfg,
   output dec_type          dec
);

   op_type      op;
   size_type    size;
   logic [31:0] trans;
   logic [31:0] phys;
   logic [32:0] acc_end;
   logic        in_ram;
   logic        in_rom;
   logic        in_scr;
   logic        in_mbx;
   logic        in_gfx;
   region_type  region;

   always_comb begin
      case (action)
         ACT_RD8:  begin op = OP_READ;  size = SZ_BYTE; end
         ACT_RD16: begin op = OP_READ;  size = SZ_HALF; end
         ACT_RD32: begin op = OP_READ;  size = SZ_WORD; end
         ACT_WR8:  begin op = OP_WRITE; size = SZ_BYTE; end
         ACT_WR16: begin op = OP_WRITE; size = SZ_HALF; end
         ACT_WR32: begin op = OP_WRITE; size = SZ_WORD; end
         ACT_LOAD: begin op = OP_LOAD;  size = SZ_WORD; end
         default:  begin op = OP_NONE;  size = SZ_WORD; end
      endcase

      // mirror segments and scratchpad fold
      if (address[31:30] == 2'b10) begin
         trans = address & KSEG_MASK;
      end else if (address[31:16] == SCR_PAGE) begin
         trans = {SCR_PAGE, 2'b00, address[13:0]};
      end else begin
         trans = address;
      end

      phys = trans;
      case (size)
         SZ_HALF: begin
            phys[0]  = 1'b0;
            acc_end  = {1'b0, phys} + 33'd2;
         end
         SZ_WORD: begin
            phys[1:0] = 2'b00;
            acc_end   = {1'b0, phys} + 33'd4;
         end
         default: begin
            acc_end = {1'b0, phys} + 33'd1;
         end
      endcase

      in_ram = cfg.ram_present && (acc_end <= {12'h000, cfg.ram_limit});
      in_rom = cfg.rom_present && (phys[31:22] == ROM_PAGE);
      in_scr = (phys[31:16] == SCR_PAGE);
      in_mbx = (size == SZ_WORD) && (phys[31:16] == MBX_PAGE);
      in_gfx = (size == SZ_WORD) && (phys[31:16] == GFX_PAGE);

      case (op)
         OP_READ: begin
            if (in_ram)      region = RGN_RAM;
            else if (in_rom) region = RGN_ROM;
            else if (in_scr) region = RGN_SCR;
            else if (in_mbx) region = RGN_MBX;
            else             region = RGN_NONE;
         end
         OP_WRITE: begin
            if (in_ram)      region = RGN_RAM;
            else if (in_scr) region = RGN_SCR;
            else if (in_gfx) region = RGN_GFX;
            else if (in_mbx) region = RGN_MBX;
            else             region = RGN_NONE;
         end
         OP_LOAD: region = RGN_ROM;
         default: region = RGN_NONE;
      endcase

      dec.op     = op;
      dec.size   = size;
      dec.region = region;
      dec.phys   = (op == OP_LOAD) ? address : phys;
   end

endmodule

`default_nettype wire

// File: design/emulated_memory_bus_decoder_core.sv
// emulated memory bus decoder: decode stage, memory banks, mailbox and result register
//
// one bus access per req item: req_tuser holds the action, req_tdata the
// address and write data. one rsp item comes back per req item, in order,
// with the read data, the region that was hit and any forwarded graphics
// register write. configuration is written through csr_wr_en/csr_index/
// csr_wr_data only while no item is in flight; the user must keep to this,
// the block does not enforce it. the address is decoded and the bank read is
// issued in the cycle of acceptance; in the merge stage the read data is
// merged, written back and the result is loaded into the rsp register. one
// item per cycle is sustained while rsp_tready is high, since each bank
// forwards its last write to a read of the same word issued in the write cycle.
// when rsp_tready is low the finished result waits in the rsp register and
// one further item is still taken into the merge stage; after that req_tready
// drops until the result is taken.
// synchronous reset empties the pipeline, clears the mailbox word and sets
// the registers to ram and rom absent with a 1 MB ram limit; ram, rom and
// scratchpad contents are not cleared and need no clearing pass.
`default_nettype none

module emulated_memory_bus_decoder_core
   import embd_pkg::*;
#(
   parameter int RAM_WORDS = 262144,
   parameter int ROM_WORDS = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,    // address, write_data
   input  wire logic [2:0]  req_tuser,    // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [95:0] rsp_tdata,    // read_data, gfx_address, gfx_data
   output logic      [3:0]  rsp_tuser,    // region_hit, gfx_write_valid
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int RAM_AW = $clog2(RAM_WORDS);
   localparam int ROM_AW = $clog2(ROM_WORDS);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   dec_type     dec;
   logic        accept;
   logic        s1_go;
   logic        s1_vld_ff;
   logic        s1_vld_in;
   dec_type     s1_ff;
   logic [31:0] s1_wdata_ff;
   logic [31:0] mbx_ff;
   logic [31:0] mbx_in;
   logic        mbx_wr;
   logic        ram_rd_en;
   logic        rom_rd_en;
   logic        scr_rd_en;
   logic        ram_wr_en;
   logic        rom_wr_en;
   logic        scr_wr_en;
   logic [31:0] ram_rd_data;
   logic [31:0] rom_rd_data;
   logic [31:0] scr_rd_data;
   logic [31:0] mem_word;
   logic [31:0] merged;
   logic [31:0] read_data_in;
   logic        gfx_vld_in;
   logic [31:0] gfx_addr_in;
   logic [31:0] gfx_data_in;
   logic        rsp_vld_ff;
   logic        rsp_vld_in;
   logic [95:0] rsp_data_ff;
   logic [3:0]  rsp_user_ff;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RAM_PRESENT: cfg_in.ram_present = csr_wr_data[0];
            CSR_RAM_LIMIT:   cfg_in.ram_limit   = csr_wr_data;
            CSR_ROM_PRESENT: cfg_in.rom_present = csr_wr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ram_present <= 1'b0;
         cfg_ff.ram_limit   <= RAM_LIMIT_RESET;
         cfg_ff.rom_present <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   embd_decode u_decode (
      .action  (req_tuser),
      .address (req_tdata[31:0]),
      .cfg     (cfg_ff),
      .dec     (dec)
   );

   // handshake and stage control
   assign s1_go      = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_go;
   assign accept     = req_tvalid && req_tready;
   assign s1_vld_in  = accept || (s1_vld_ff && !s1_go);
   assign rsp_vld_in = s1_go || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= dec;
         s1_wdata_ff <= req_tdata[63:32];
      end
   end

   // bank reads issued at acceptance
   assign ram_rd_en = accept && dec.region == RGN_RAM;
   assign rom_rd_en = accept && dec.region == RGN_ROM && dec.op == OP_READ;
   assign scr_rd_en = accept && dec.region == RGN_SCR;

   // write-back at the end of the merge stage
   assign ram_wr_en = s1_go && s1_ff.op == OP_WRITE && s1_ff.region == RGN_RAM;
   assign scr_wr_en = s1_go && s1_ff.op == OP_WRITE && s1_ff.region == RGN_SCR;
   assign rom_wr_en = s1_go && s1_ff.op == OP_LOAD;
   assign mbx_wr    = s1_go && s1_ff.op == OP_WRITE && s1_ff.region == RGN_MBX;

   embd_bank #(.DEPTH(RAM_WORDS)) u_ram_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ram_rd_en),
      .rd_idx  (dec.phys[2 +: RAM_AW]),
      .wr_en   (ram_wr_en),
      .wr_idx  (s1_ff.phys[2 +: RAM_AW]),
      .wr_data (merged),
      .rd_data (ram_rd_data)
   );

   embd_bank #(.DEPTH(ROM_WORDS)) u_rom_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rom_rd_en),
      .rd_idx  (dec.phys[2 +: ROM_AW]),
      .wr_en   (rom_wr_en),
      .wr_idx  (s1_ff.phys[2 +: ROM_AW]),
      .wr_data (s1_wdata_ff),
      .rd_data (rom_rd_data)
   );

   embd_bank #(.DEPTH(SCRATCH_WORDS)) u_scr_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (scr_rd_en),
      .rd_idx  (dec.phys[2 +: SCR_AW]),
      .wr_en   (scr_wr_en),
      .wr_idx  (s1_ff.phys[2 +: SCR_AW]),
      .wr_data (merged),
      .rd_data (scr_rd_data)
   );

   // mailbox word
   assign mbx_in = mbx_wr ? s1_wdata_ff : mbx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mbx_ff <= 32'h0000_0000;
      end else begin
         mbx_ff <= mbx_in;
      end
   end

   // merge stage
   always_comb begin
      case (s1_ff.region)
         RGN_RAM: mem_word = ram_rd_data;
         RGN_ROM: mem_word = rom_rd_data;
         RGN_SCR: mem_word = scr_rd_data;
         default: mem_word = 32'h0000_0000;
      endcase

      merged = lane_put(mem_word, s1_ff.phys[1:0], s1_ff.size, s1_wdata_ff);

      read_data_in = 32'h0000_0000;
      if (s1_ff.op == OP_READ) begin
         case (s1_ff.region)
            RGN_RAM, RGN_ROM, RGN_SCR:
               read_data_in = lane_get(mem_word, s1_ff.phys[1:0], s1_ff.size);
            RGN_MBX: read_data_in = mbx_ff;
            default: read_data_in = 32'h0000_0000;
         endcase
      end

      gfx_vld_in  = s1_ff.region == RGN_GFX;
      gfx_addr_in = gfx_vld_in ? s1_ff.phys  : 32'h0000_0000;
      gfx_data_in = gfx_vld_in ? s1_wdata_ff : 32'h0000_0000;
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= {gfx_data_in, gfx_addr_in, read_data_in};
         rsp_user_ff <= {gfx_vld_in, s1_ff.region};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_reset_empties_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_load_reports_rom: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_ff.op == OP_LOAD |=>
         rsp_tvalid && rsp_tuser[2:0] == RGN_ROM && rsp_tdata[31:0] == 32'h0000_0000)
      else $error("rom load result wrong");

   a_gfx_is_write_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |->
         rsp_tuser[2:0] == RGN_GFX && rsp_tdata[31:0] == 32'h0000_0000)
      else $error("graphics forward on a non-graphics result");

   a_writes_from_stage: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en || scr_wr_en || rom_wr_en || mbx_wr) |->
         s1_vld_ff && !(ram_wr_en && scr_wr_en) && !(rom_wr_en && mbx_wr))
      else $error("bank write without a single item in the merge stage");

endmodule

`default_nettype wire
